[rtl/assert_macros.svh]
// assertion helper macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/c80_pkg.sv]
// shared types and codes of the 8080 subset execute core
// no dependencies
package c80_pkg;

  localparam int MEM_ADDR_BITS_DEF = 16;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_HLT = 2'd1,
    ST_BAD = 2'd2
  } status_e;

  // register codes in opcode fields
  localparam logic [2:0] R_B = 3'd0;
  localparam logic [2:0] R_C = 3'd1;
  localparam logic [2:0] R_D = 3'd2;
  localparam logic [2:0] R_E = 3'd3;
  localparam logic [2:0] R_H = 3'd4;
  localparam logic [2:0] R_L = 3'd5;
  localparam logic [2:0] R_M = 3'd6;
  localparam logic [2:0] R_A = 3'd7;

  localparam logic [1:0] RP_BC = 2'd0;
  localparam logic [1:0] RP_DE = 2'd1;
  localparam logic [1:0] RP_HL = 2'd2;
  localparam logic [1:0] RP_SP = 2'd3;

  localparam logic [1:0] GRP_LOW = 2'b00;
  localparam logic [1:0] GRP_MOV = 2'b01;

  localparam logic [2:0] LO3_INR = 3'd4;
  localparam logic [2:0] LO3_DCR = 3'd5;
  localparam logic [2:0] LO3_MVI = 3'd6;
  localparam logic [3:0] LO4_LXI = 4'h1;
  localparam logic [3:0] LO4_INX = 4'h3;
  localparam logic [3:0] LO4_DAD = 4'h9;
  localparam logic [3:0] LO4_DCX = 4'hB;

  localparam logic [7:0] OP_NOP   = 8'h00;
  localparam logic [7:0] OP_STAXB = 8'h02;
  localparam logic [7:0] OP_RLC   = 8'h07;
  localparam logic [7:0] OP_LDAXB = 8'h0A;
  localparam logic [7:0] OP_RRC   = 8'h0F;
  localparam logic [7:0] OP_STAXD = 8'h12;
  localparam logic [7:0] OP_RAL   = 8'h17;
  localparam logic [7:0] OP_LDAXD = 8'h1A;
  localparam logic [7:0] OP_RAR   = 8'h1F;
  localparam logic [7:0] OP_SHLD  = 8'h22;
  localparam logic [7:0] OP_DAA   = 8'h27;
  localparam logic [7:0] OP_LHLD  = 8'h2A;
  localparam logic [7:0] OP_CMA   = 8'h2F;
  localparam logic [7:0] OP_STA   = 8'h32;
  localparam logic [7:0] OP_STC   = 8'h37;
  localparam logic [7:0] OP_LDA   = 8'h3A;
  localparam logic [7:0] OP_CMC   = 8'h3F;
  localparam logic [7:0] OP_HLT   = 8'h76;

  typedef struct packed {
    logic        en;
    logic        we;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } mem_req_t;

  typedef struct packed {
    logic idle;
    logic halted;
    logic res_push;
    logic res_stop;
  } seq_stat_t;

  typedef struct packed {
    logic s;
    logic z;
    logic ac;
    logic p;
    logic c;
  } flags_t;

endpackage

[rtl/c80_in_if.sv]
// input channel of the 8080 subset execute core
// no dependencies
interface c80_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] mem_address;
  logic [7:0]  mem_data;

  modport source (output valid, command, mem_address, mem_data, input ready);
  modport sink (input valid, command, mem_address, mem_data, output ready);
endinterface

[rtl/c80_out_if.sv]
// result channel of the 8080 subset execute core
// no dependencies
interface c80_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  out_a;
  logic [7:0]  out_b;
  logic [7:0]  out_c;
  logic [7:0]  out_d;
  logic [7:0]  out_e;
  logic [7:0]  out_h;
  logic [7:0]  out_l;
  logic [15:0] out_sp;
  logic [15:0] out_pc;
  logic [7:0]  out_flags;

  modport source (output valid, status, out_a, out_b, out_c, out_d, out_e, out_h, out_l,
                  out_sp, out_pc, out_flags, input ready);
  modport sink (input valid, status, out_a, out_b, out_c, out_d, out_e, out_h, out_l,
                out_sp, out_pc, out_flags, output ready);
endinterface

[rtl/c80_mem.sv]
// single-port byte memory, registered read data
// depends on c80_pkg
module c80_mem #(
  parameter int MEM_ADDR_BITS = 16
) (
  input  logic              clk_i,
  input  c80_pkg::mem_req_t req_i,
  output logic [7:0]        rdata_o
);
  import c80_pkg::*;

  logic [7:0] mem_q [2**MEM_ADDR_BITS];
  logic [7:0] rdata_q;
  logic [MEM_ADDR_BITS-1:0] idx;

  assign idx = req_i.addr[MEM_ADDR_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem_q[idx] <= req_i.wdata;
      end else begin
        rdata_q <= mem_q[idx];
      end
    end
  end

  assign rdata_o = rdata_q;
endmodule

[rtl/c80_seq.sv]
// instruction sequencer: register file, flags, pc/sp and result register
// depends on c80_pkg and the channel interfaces
module c80_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              hold_i,
  c80_in_if.sink            in_i,
  c80_out_if.source         res_o,
  output c80_pkg::mem_req_t mem_req_o,
  input  logic [7:0]        rdata_i,
  output c80_pkg::seq_stat_t stat_o
);
  import c80_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OP   = 3'd1;
  localparam logic [2:0] S_B1   = 3'd2;
  localparam logic [2:0] S_B2   = 3'd3;
  localparam logic [2:0] S_D1   = 3'd4;
  localparam logic [2:0] S_D2   = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [7:0]  op_q, op_d, lo_q, lo_d;
  logic [15:0] adr_q, adr_d;
  logic [7:0]  a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d, e_q, e_d, h_q, h_d, l_q, l_d;
  logic [15:0] sp_q, sp_d, pc_q, pc_d;
  flags_t      fl_q, fl_d;
  logic        halted_q, halted_d;
  status_e     status_q, status_d;
  logic        ovalid_q, ovalid_d;
  status_e     rstat_q;
  logic [7:0]  ra_q, rb_q, rc_q, rd_q, re_q, rh_q, rl_q, rf_q;
  logic [15:0] rsp_q, rpc_q;

  logic [7:0]  op, src_v, dst_v, base_v, res8, wr_v;
  logic [2:0]  dst, src, wr_sel;
  logic [1:0]  rp, rpw_sel;
  logic [15:0] hl, rp_v, adr, rpw_v;
  logic [16:0] sum;
  logic        ac, wr_en, rpw_en, set_f, accept, out_free, push;
  mem_req_t    req;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !ovalid_q || res_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && !hold_i;

  always_comb begin
    op  = (state_q == S_OP) ? rdata_i : op_q;
    dst = op[5:3];
    src = op[2:0];
    rp  = op[5:4];
    hl  = {h_q, l_q};
    adr = {rdata_i, lo_q};
    case (src)
      R_B:     src_v = b_q;
      R_C:     src_v = c_q;
      R_D:     src_v = d_q;
      R_E:     src_v = e_q;
      R_H:     src_v = h_q;
      R_L:     src_v = l_q;
      R_A:     src_v = a_q;
      default: src_v = rdata_i;
    endcase
    case (dst)
      R_B:     dst_v = b_q;
      R_C:     dst_v = c_q;
      R_D:     dst_v = d_q;
      R_E:     dst_v = e_q;
      R_H:     dst_v = h_q;
      R_L:     dst_v = l_q;
      R_A:     dst_v = a_q;
      default: dst_v = rdata_i;
    endcase
    case (rp)
      RP_BC:   rp_v = {b_q, c_q};
      RP_DE:   rp_v = {d_q, e_q};
      RP_HL:   rp_v = hl;
      default: rp_v = sp_q;
    endcase
    sum    = {1'b0, hl} + {1'b0, rp_v};
    base_v = (state_q == S_D1) ? rdata_i : dst_v;
    // op bit 0 tells dcr from inr
    res8   = op[0] ? (base_v - 8'd1) : (base_v + 8'd1);
    ac     = op[0] ? (base_v[3:0] != 4'h0) : (base_v[3:0] == 4'hF);

    state_d = state_q; op_d = op_q; lo_d = lo_q; adr_d = adr_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; e_d = e_q; h_d = h_q; l_d = l_q;
    sp_d = sp_q; pc_d = pc_q; fl_d = fl_q; halted_d = halted_q; status_d = status_q;
    req = '0;
    wr_en = 1'b0; wr_sel = dst; wr_v = src_v;
    rpw_en = 1'b0; rpw_sel = rp; rpw_v = adr;
    set_f = 1'b0; push = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d  = S_FIN;
          status_d = ST_OK;
          if (in_i.command == CMD_LOAD) begin
            req = '{en: 1'b1, we: 1'b1, addr: in_i.mem_address, wdata: in_i.mem_data};
          end else if (halted_q) begin
            status_d = ST_HLT;
          end else begin
            req = '{en: 1'b1, we: 1'b0, addr: pc_q, wdata: 8'h00};
            pc_d = pc_q + 16'd1;
            state_d = S_OP;
          end
        end
      end
      S_OP: begin
        op_d    = rdata_i;
        state_d = S_FIN;
        if (op == OP_HLT) begin
          halted_d = 1'b1;
          status_d = ST_HLT;
        end else if (op[7:6] == GRP_MOV) begin
          if (src == R_M) begin
            req = '{en: 1'b1, we: 1'b0, addr: hl, wdata: 8'h00};
            state_d = S_D1;
          end else if (dst == R_M) begin
            req = '{en: 1'b1, we: 1'b1, addr: hl, wdata: src_v};
          end else begin
            wr_en = 1'b1;
          end
        end else if (op[7:6] != GRP_LOW) begin
          halted_d = 1'b1;
          status_d = ST_BAD;
        end else if (src == LO3_INR || src == LO3_DCR) begin
          if (dst == R_M) begin
            req = '{en: 1'b1, we: 1'b0, addr: hl, wdata: 8'h00};
            state_d = S_D1;
          end else begin
            wr_en = 1'b1;
            wr_v  = res8;
            set_f = 1'b1;
          end
        end else if (src == LO3_MVI || op[3:0] == LO4_LXI || op == OP_SHLD ||
                     op == OP_LHLD || op == OP_STA || op == OP_LDA) begin
          req = '{en: 1'b1, we: 1'b0, addr: pc_q, wdata: 8'h00};
          pc_d = pc_q + 16'd1;
          state_d = S_B1;
        end else if (op[3:0] == LO4_INX) begin
          rpw_en = 1'b1;
          rpw_v  = rp_v + 16'd1;
        end else if (op[3:0] == LO4_DCX) begin
          rpw_en = 1'b1;
          rpw_v  = rp_v - 16'd1;
        end else if (op[3:0] == LO4_DAD) begin
          rpw_en  = 1'b1;
          rpw_sel = RP_HL;
          rpw_v   = sum[15:0];
          fl_d.c  = sum[16];
        end else begin
          case (op)
            OP_NOP, OP_DAA: ;
            OP_STAXB, OP_STAXD: req = '{en: 1'b1, we: 1'b1, addr: rp_v, wdata: a_q};
            OP_LDAXB, OP_LDAXD: begin
              req = '{en: 1'b1, we: 1'b0, addr: rp_v, wdata: 8'h00};
              state_d = S_D1;
            end
            OP_RLC: begin
              fl_d.c = a_q[7];
              a_d    = {a_q[6:0], a_q[7]};
            end
            OP_RRC: begin
              fl_d.c = a_q[0];
              a_d    = {a_q[0], a_q[7:1]};
            end
            OP_RAL: begin
              fl_d.c = a_q[7];
              a_d    = {a_q[6:0], fl_q.c};
            end
            OP_RAR: begin
              fl_d.c = a_q[0];
              a_d    = {fl_q.c, a_q[7:1]};
            end
            OP_CMA: a_d = ~a_q;
            OP_STC: fl_d.c = 1'b1;
            OP_CMC: fl_d.c = ~fl_q.c;
            default: begin
              halted_d = 1'b1;
              status_d = ST_BAD;
            end
          endcase
        end
      end
      S_B1: begin
        if (src == LO3_MVI) begin
          state_d = S_FIN;
          if (dst == R_M) begin
            req = '{en: 1'b1, we: 1'b1, addr: hl, wdata: rdata_i};
          end else begin
            wr_en = 1'b1;
            wr_v  = rdata_i;
          end
        end else begin
          lo_d = rdata_i;
          req  = '{en: 1'b1, we: 1'b0, addr: pc_q, wdata: 8'h00};
          pc_d = pc_q + 16'd1;
          state_d = S_B2;
        end
      end
      S_B2: begin
        state_d = S_FIN;
        adr_d   = adr + 16'd1;
        if (op[3:0] == LO4_LXI) begin
          rpw_en = 1'b1;
        end else begin
          case (op)
            OP_SHLD: begin
              req = '{en: 1'b1, we: 1'b1, addr: adr, wdata: l_q};
              state_d = S_D2;
            end
            OP_LHLD, OP_LDA: begin
              req = '{en: 1'b1, we: 1'b0, addr: adr, wdata: 8'h00};
              state_d = S_D1;
            end
            default: req = '{en: 1'b1, we: 1'b1, addr: adr, wdata: a_q};
          endcase
        end
      end
      S_D1: begin
        state_d = S_FIN;
        if (op[7:6] == GRP_MOV) begin
          wr_en = 1'b1;
          wr_v  = rdata_i;
        end else if (src == LO3_INR || src == LO3_DCR) begin
          req   = '{en: 1'b1, we: 1'b1, addr: hl, wdata: res8};
          set_f = 1'b1;
        end else if (op == OP_LHLD) begin
          l_d = rdata_i;
          req = '{en: 1'b1, we: 1'b0, addr: adr_q, wdata: 8'h00};
          state_d = S_D2;
        end else begin
          a_d = rdata_i;
        end
      end
      S_D2: begin
        state_d = S_FIN;
        if (op == OP_SHLD) begin
          req = '{en: 1'b1, we: 1'b1, addr: adr_q, wdata: h_q};
        end else begin
          h_d = rdata_i;
        end
      end
      S_FIN: begin
        if (out_free) begin
          push    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (wr_en) begin
      case (wr_sel)
        R_B:     b_d = wr_v;
        R_C:     c_d = wr_v;
        R_D:     d_d = wr_v;
        R_E:     e_d = wr_v;
        R_H:     h_d = wr_v;
        R_L:     l_d = wr_v;
        default: a_d = wr_v;
      endcase
    end
    if (rpw_en) begin
      case (rpw_sel)
        RP_BC:   {b_d, c_d} = rpw_v;
        RP_DE:   {d_d, e_d} = rpw_v;
        RP_HL:   {h_d, l_d} = rpw_v;
        default: sp_d = rpw_v;
      endcase
    end
    if (set_f) begin
      fl_d.s  = res8[7];
      fl_d.z  = (res8 == 8'h00);
      fl_d.p  = ~^res8;
      fl_d.ac = ac;
    end

    ovalid_d = ovalid_q;
    if (ovalid_q && res_o.ready) ovalid_d = 1'b0;
    if (push) ovalid_d = 1'b1;
  end

  assign mem_req_o = req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0; e_q <= '0; h_q <= '0; l_q <= '0;
      sp_q <= '0; pc_q <= '0; fl_q <= '0; halted_q <= 1'b0;
      status_q <= ST_OK;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d; e_q <= e_d; h_q <= h_d; l_q <= l_d;
      sp_q <= sp_d; pc_q <= pc_d; fl_q <= fl_d; halted_q <= halted_d;
      status_q <= status_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    lo_q  <= lo_d;
    adr_q <= adr_d;
    if (push) begin
      rstat_q <= status_q;
      ra_q <= a_q; rb_q <= b_q; rc_q <= c_q; rd_q <= d_q;
      re_q <= e_q; rh_q <= h_q; rl_q <= l_q;
      rsp_q <= sp_q; rpc_q <= pc_q;
      rf_q <= {fl_q.s, fl_q.z, 1'b0, fl_q.ac, 1'b0, fl_q.p, 1'b0, fl_q.c};
    end
  end

  assign res_o.valid     = ovalid_q;
  assign res_o.status    = rstat_q;
  assign res_o.out_a     = ra_q;
  assign res_o.out_b     = rb_q;
  assign res_o.out_c     = rc_q;
  assign res_o.out_d     = rd_q;
  assign res_o.out_e     = re_q;
  assign res_o.out_h     = rh_q;
  assign res_o.out_l     = rl_q;
  assign res_o.out_sp    = rsp_q;
  assign res_o.out_pc    = rpc_q;
  assign res_o.out_flags = rf_q;

  assign stat_o = '{idle: (state_q == S_IDLE), halted: halted_q, res_push: push,
                    res_stop: (status_q != ST_OK)};
endmodule

[rtl/cpu8080_subset_execute_core.sv]
// top level of the 8080 subset execute core: memory clear sweep, memory, sequencer
// depends on c80_pkg, c80_in_if, c80_out_if, c80_mem, c80_seq, assert_macros.svh
//
// channel | dir | payload
// in_i    | in  | command, mem_address, mem_data
// res_o   | out | status, out_a..out_l, out_sp, out_pc, out_flags
//
// after reset the memory is swept to zero, one byte a cycle, with in_i.ready low.
// a load item passes idle and fin; a step item idle, op (skipped when halted),
// b1, b2, d1, d2 as needed (none for nop, mov r,r; all four for lhld), then fin, which
// hands its result to the output register once that is free; the steps are set by the
// single memory port (opcode, up to two operand bytes, up to two data accesses).
// a finished result waits in the output register; the next item is taken meanwhile.
module cpu8080_subset_execute_core #(
  parameter int MEM_ADDR_BITS = c80_pkg::MEM_ADDR_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  c80_in_if.sink    in_i,
  c80_out_if.source res_o
);
  import c80_pkg::*;

  logic [MEM_ADDR_BITS:0] clr_cnt_q, clr_cnt_d;
  logic                   clr_busy;
  mem_req_t               seq_req, mem_req;
  logic [7:0]             rdata;
  seq_stat_t              stat;

  assign clr_busy  = !clr_cnt_q[MEM_ADDR_BITS];
  assign clr_cnt_d = clr_cnt_q + {{MEM_ADDR_BITS{1'b0}}, 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (clr_busy) begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_comb begin
    if (clr_busy) begin
      mem_req = '{en: 1'b1, we: 1'b1, addr: 16'(clr_cnt_q[MEM_ADDR_BITS-1:0]), wdata: 8'h00};
    end else begin
      mem_req = seq_req;
    end
  end

  c80_mem #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  c80_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .hold_i    (clr_busy),
    .in_i      (in_i),
    .res_o     (res_o),
    .mem_req_o (seq_req),
    .rdata_i   (rdata),
    .stat_o    (stat)
  );

`include "assert_macros.svh"

  `ASSERT_SAME(a_clr_blocks_in, clk_i, rst_ni, clr_busy, !in_i.ready)
  `ASSERT_SAME(a_busy_blocks_in, clk_i, rst_ni, !stat.idle, !in_i.ready)
  `ASSERT_NEXT(a_stop_halts, clk_i, rst_ni, stat.res_push && stat.res_stop, stat.halted)
endmodule
